// ===== hw/rtl/lcot_pkg.sv =====
// ----------------------------------------------------------------------------
// lcot_pkg
// Shared constants and helper functions of the online-trained
// logistic classifier.
// ----------------------------------------------------------------------------
package lcot_pkg;

  localparam int MaxClasses  = 4;
  localparam int MaxFeatures = 7;
  localparam int WgtW        = 24;
  localparam int QW          = 16;
  localparam logic [QW-1:0] QOne = 16'd32768;
  localparam logic [16:0] RateMin = 17'd7;
  localparam logic [16:0] RateMax = 17'd65536;
  localparam logic [13:0] EpochMax = 14'd10000;

  // register indexes
  localparam logic CfgLearnRate  = 1'b0;
  localparam logic CfgEpochCount = 1'b1;

  // request kinds
  localparam logic ReqPredict = 1'b0;
  localparam logic ReqTrain   = 1'b1;

  // reset weights, row-major class by feature, Q8.16
  function automatic logic signed [WgtW-1:0] init_weight(input int r, input int c);
    int v;
    begin
      v = 0;
      case (r*MaxFeatures + c)
        0: v = -85197;  1: v = -52429;  2: v = -65536;  3: v = -65536;
        4: v = -32768;  5: v = -45875;  6: v = -45875;
        7: v = 104858;  8: v = 26214;   9: v = 13107;   10: v = 32768;
        11: v = 39322;  12: v = 72090;  13: v = 52429;
        14: v = 32768;  15: v = 52429;  16: v = 117965; 17: v = 19661;
        18: v = 26214;  19: v = 19661;  20: v = 52429;
        21: v = 45875;  22: v = 19661;  23: v = 13107;  24: v = 124518;
        25: v = 19661;  26: v = 13107;  27: v = 58982;
        default: v = 0;
      endcase
      return v[WgtW-1:0];
    end
  endfunction

  function automatic logic signed [WgtW-1:0] init_bias(input int r);
    int v;
    begin
      case (r)
        0: v = 78643;
        1: v = -52429;
        2: v = -65536;
        3: v = -65536;
        default: v = 0;
      endcase
      return v[WgtW-1:0];
    end
  endfunction

  // sigmoid knots at integer x, Q1.15
  function automatic logic [QW-1:0] sig_knot(input logic [3:0] k);
    logic [QW-1:0] v;
    begin
      case (k)
        4'd0: v = 16'd16384;
        4'd1: v = 16'd23955;
        4'd2: v = 16'd28862;
        4'd3: v = 16'd31214;
        4'd4: v = 16'd32179;
        4'd5: v = 16'd32549;
        4'd6: v = 16'd32687;
        4'd7: v = 16'd32738;
        default: v = 16'd32757;
      endcase
      return v;
    end
  endfunction

  function automatic logic [QW-1:0] sat_q(input logic [QW-1:0] v);
    return (v > QOne) ? QOne : v;
  endfunction

endpackage

// ===== hw/rtl/lcot_sigmoid.sv =====
// ----------------------------------------------------------------------------
// lcot_sigmoid
// Registered piecewise-linear sigmoid over [-8,8): one knot-pair lookup and
// one 16x16 interpolation product, registered in the cycle after the request.
// ----------------------------------------------------------------------------
module lcot_sigmoid import lcot_pkg::*; #(
  parameter int AccW = 48
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [AccW-1:0] x_i,
  output logic                   done_o,
  output logic [QW-1:0]          y_o
);

  logic            neg;
  logic [AccW-1:0] mag;
  logic            over;
  logic [3:0]      k;
  logic [15:0]     fr;
  logic [QW-1:0]   lo, hi, sp;
  logic [31:0]     prod;
  logic [QW-1:0]   y_d, y_q;
  logic            done_q;

  // magnitude split into knot index and fraction
  always_comb begin
    neg  = x_i[AccW-1];
    mag  = neg ? (AccW)'(-x_i) : x_i;
    over = (mag[AccW-1:19] != '0);
    k    = {1'b0, mag[18:16]};
    fr   = mag[15:0];
    lo   = sig_knot(k);
    hi   = sig_knot(k + 4'd1);
    prod = 32'(hi - lo) * 32'(fr);
    sp   = over ? sig_knot(4'd8) : 16'(lo + prod[31:16]);
    if (!neg) begin
      y_d = over ? QOne : sp;
    end else begin
      // x == -8 exactly maps to 1 - s(8); below that saturate to zero
      if (over && (mag != (AccW)'(32'd524288))) y_d = '0;
      else y_d = 16'(QOne - sp);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) y_q <= y_d;
  end

  assign done_o = done_q;
  assign y_o    = y_q;

`ifndef SYNTHESIS
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> done_o) else $error("sigmoid done missing");
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (y_o <= QOne)) else $error("sigmoid out of range");
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start_i |=> !done_o) else $error("sigmoid spurious done");
`endif

endmodule

// ===== hw/rtl/lcot_param_mem.sv =====
// ----------------------------------------------------------------------------
// lcot_param_mem
// Weight and bias store: one synchronous memory, one write and one read port,
// read data registered. Entries below the weight count hold weights, the
// entries above hold biases. Reset values come from valid bits.
// ----------------------------------------------------------------------------
module lcot_param_mem import lcot_pkg::*; #(
  parameter int NumClasses  = MaxClasses,
  parameter int NumFeatures = MaxFeatures,
  parameter int Depth       = NumClasses*(NumFeatures+1),
  parameter int AddrW       = $clog2(Depth)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   rd_en_i,
  input  logic [AddrW-1:0]       rd_addr_i,
  output logic signed [WgtW-1:0] rd_data_o,
  input  logic                   wr_en_i,
  input  logic [AddrW-1:0]       wr_addr_i,
  input  logic signed [WgtW-1:0] wr_data_i
);

  localparam int NumW = NumClasses*NumFeatures;

  logic signed [WgtW-1:0] mem_q [Depth];
  logic [Depth-1:0]       vld_q;
  logic signed [WgtW-1:0] raw_q;
  logic signed [WgtW-1:0] init_q;
  logic                   hit_q;
  logic signed [WgtW-1:0] init_d;

  // reset value of the addressed entry
  always_comb begin
    init_d = '0;
    for (int i = 0; i < Depth; i++) begin
      if (rd_addr_i == AddrW'(i)) begin
        if (i < NumW) init_d = init_weight(i / NumFeatures, i % NumFeatures);
        else init_d = init_bias(i - NumW);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem_q[wr_addr_i] <= wr_data_i;
    if (rd_en_i) begin
      raw_q  <= mem_q[rd_addr_i];
      init_q <= init_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      hit_q <= 1'b0;
    end else begin
      if (wr_en_i) vld_q[wr_addr_i] <= 1'b1;
      if (rd_en_i) hit_q <= vld_q[rd_addr_i];
    end
  end

  assign rd_data_o = hit_q ? raw_q : init_q;

`ifndef SYNTHESIS
  a_wr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i |-> ({1'b0, wr_addr_i} < (AddrW+1)'(Depth))) else $error("write out of range");
  a_rd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_i |-> ({1'b0, rd_addr_i} < (AddrW+1)'(Depth))) else $error("read out of range");
  a_no_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en_i && wr_en_i) |-> (rd_addr_i != wr_addr_i)) else $error("same-entry overlap");
`endif

endmodule

// ===== hw/rtl/logistic_classifier_online_train.sv =====
// ----------------------------------------------------------------------------
// logistic_classifier_online_train
// Four-class logistic classifier with on-line delta-rule training.
// ----------------------------------------------------------------------------
// Usage: configuration words (index 0 learn rate, 1 epoch count) arrive on
// cfg_valid_i/cfg_ready_o/cfg_index_i/cfg_data_i and are taken only while
// idle; a pending configuration word goes ahead of a request in that cycle.
// Request words enter on s_axis_*; tuser carries req_type. One result
// word per request leaves on m_axis_*, tuser carrying was_train.
// Sequencing: all parameters live in one memory with one read port, so a
// row is read one word at a time. Predict, per class, issues F+1 reads, adds
// the bias term, starts the sigmoid, takes its result and steps to the next
// class. Train runs, per epoch and class, the forward pass and then a
// read-modify-write sweep of the row. The memory read port paces both passes.
// Reset restores the fixed initial weights and biases through per-entry
// valid bits, learn rate 655 and one epoch. A result waits in the output
// register while m_axis_tready is low; the next request is taken once that
// result has left.
// ----------------------------------------------------------------------------
module logistic_classifier_online_train import lcot_pkg::*; #(
  parameter int NumClasses  = MaxClasses,
  parameter int NumFeatures = MaxFeatures
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic          cfg_index_i,
  input  logic [16:0]   cfg_data_i,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // tdata: feat_override, feat_hierarchy, feat_secret, feat_privilege,
  // feat_obfuscation, feat_indirect, feat_tool_abuse, target_benign,
  // target_injection, target_exfil, target_priv (16 bits each, low first)
  input  logic [175:0]  s_axis_tdata,
  // tuser: req_type
  input  logic          s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // tdata: prob_benign, prob_injection, prob_exfiltration, prob_privilege,
  // peak risk (16 bits each, low first)
  output logic [79:0]   m_axis_tdata,
  // tuser: was_train
  output logic          m_axis_tuser
);

  localparam int Depth = NumClasses*(NumFeatures+1);
  localparam int AddrW = $clog2(Depth);
  localparam int NumW  = NumClasses*NumFeatures;
  localparam int FW    = (NumFeatures > 1) ? $clog2(NumFeatures+1) : 1;
  localparam int CW    = $clog2(NumClasses);
  localparam int AccW  = 48;

  // states
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StFwd  = 3'd1;
  localparam logic [2:0] StSig  = 3'd2;
  localparam logic [2:0] StUpd  = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  logic [2:0]  st_q, st_d;
  logic [16:0] rate_q;
  logic [13:0] epoch_q;
  logic [QW-1:0] feat_q [NumFeatures];
  logic [QW-1:0] tgt_q  [NumClasses];
  logic        train_q;
  logic [CW-1:0] cls_q;
  logic [FW-1:0] idx_q;     // read index within row (NumFeatures = bias)
  logic        rvld_q;      // read data valid (registered read enable)
  logic [FW-1:0] ridx_q;
  logic [13:0] ep_q;
  logic signed [AccW-1:0] acc_q;
  logic [QW-1:0] prob_q [MaxClasses];
  logic signed [QW:0] err_q;
  logic signed [34:0] re_q;   // rate*error
  logic        re_vld_q;
  logic        last_issued_q;
  logic        sig_busy_q;

  logic        rd_en, wr_en;
  logic [AddrW-1:0] rd_addr, wr_addr;
  logic signed [WgtW-1:0] rd_data, wr_data;
  logic        sig_start, sig_done;
  logic [QW-1:0] sig_y;

  logic [16:0] rate_c;
  logic [13:0] epochs_c;

  assign rate_c = (rate_q < RateMin) ? RateMin : (rate_q > RateMax) ? RateMax : rate_q;
  assign epochs_c = (epoch_q == '0) ? 14'd1 : (epoch_q > EpochMax) ? EpochMax : epoch_q;

  assign cfg_ready_o   = (st_q == StIdle);
  assign s_axis_tready = (st_q == StIdle) && !cfg_valid_i;

  // address of a row entry
  function automatic logic [AddrW-1:0] ent(input logic [CW-1:0] c, input logic [FW-1:0] f);
    if (f == FW'(NumFeatures)) return AddrW'(NumW) + AddrW'(c);
    return AddrW'(c) * AddrW'(NumFeatures) + AddrW'(f);
  endfunction

  lcot_param_mem #(
    .NumClasses (NumClasses),
    .NumFeatures(NumFeatures)
  ) u_mem (
    .clk_i, .rst_ni,
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

  lcot_sigmoid #(.AccW(AccW)) u_sig (
    .clk_i, .rst_ni,
    .start_i(sig_start),
    .x_i    (acc_q >>> 15),
    .done_o (sig_done),
    .y_o    (sig_y)
  );

  // feature paired with the word in flight
  logic [QW-1:0] feat_sel;
  always_comb begin
    feat_sel = '0;
    for (int i = 0; i < NumFeatures; i++)
      if (ridx_q == FW'(i)) feat_sel = feat_q[i];
  end

  // multiply of read word by its feature, bias scaled by 2^15
  logic signed [AccW-1:0] term;
  always_comb begin
    if (ridx_q == FW'(NumFeatures)) term = AccW'(rd_data) <<< 15;
    else term = AccW'(rd_data) * $signed({1'b0, feat_sel});
  end

  // update step for the read word
  logic signed [AccW-1:0] prod_u, step, sum_u;
  logic [5:0] sh;
  always_comb begin
    if (ridx_q == FW'(NumFeatures)) begin
      prod_u = AccW'(re_q);
      sh = 6'd17;
    end else begin
      prod_u = AccW'(re_q) * $signed({1'b0, feat_sel});
      sh = 6'd30;
    end
    step  = (prod_u + (AccW'(1) <<< (sh - 6'd1))) >>> sh;
    sum_u = AccW'(rd_data) + step;
    if (sum_u > AccW'(24'sh7FFFFF)) wr_data = 24'sh7FFFFF;
    else if (sum_u < AccW'(-64'sd8388608)) wr_data = 24'sh800000;
    else wr_data = sum_u[WgtW-1:0];
  end

  // sequencing
  logic last_rd;
  assign last_rd = (idx_q == FW'(NumFeatures));
  assign rd_en   = ((st_q == StFwd) || (st_q == StUpd && re_vld_q)) && !last_issued_q;
  assign rd_addr = ent(cls_q, idx_q);
  assign wr_en   = (st_q == StUpd) && rvld_q;
  assign wr_addr = ent(cls_q, ridx_q);
  assign sig_start = (st_q == StFwd) && last_issued_q && !rvld_q && !sig_busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      rate_q <= 17'd655;
      epoch_q <= 14'd1;
      rvld_q <= 1'b0;
      last_issued_q <= 1'b0;
      sig_busy_q <= 1'b0;
      re_vld_q <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      rvld_q <= rd_en;
      case (st_q)
        StIdle: begin
          if (cfg_valid_i && cfg_ready_o) begin
            if (cfg_index_i == CfgLearnRate) rate_q <= cfg_data_i;
            else epoch_q <= cfg_data_i[13:0];
          end
          if (s_axis_tvalid && s_axis_tready) st_q <= StFwd;
        end
        StFwd: begin
          if (rd_en && last_rd) last_issued_q <= 1'b1;
          if (sig_start) sig_busy_q <= 1'b1;
          if (sig_done) begin
            sig_busy_q <= 1'b0;
            last_issued_q <= 1'b0;
            st_q <= train_q ? StUpd : StSig;
          end
        end
        StSig: begin
          if (cls_q == CW'(NumClasses-1)) begin
            st_q <= StOut;
            m_axis_tvalid <= 1'b1;
          end else st_q <= StFwd;
        end
        StUpd: begin
          if (rd_en && last_rd) last_issued_q <= 1'b1;
          if (wr_en && ridx_q == FW'(NumFeatures)) begin
            re_vld_q <= 1'b0;
            last_issued_q <= 1'b0;
            if (cls_q == CW'(NumClasses-1) && ep_q == epochs_c - 14'd1) begin
              st_q <= StOut;
              m_axis_tvalid <= 1'b1;
            end else st_q <= StFwd;
          end else re_vld_q <= 1'b1;
        end
        StOut: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            st_q <= StIdle;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (rd_en) ridx_q <= idx_q;
    case (st_q)
      StIdle: begin
        for (int f = 0; f < NumFeatures; f++)
          feat_q[f] <= sat_q(s_axis_tdata[16*f +: 16]);
        for (int c = 0; c < NumClasses; c++)
          tgt_q[c] <= sat_q(s_axis_tdata[16*(MaxFeatures+c) +: 16]);
        for (int c = 0; c < MaxClasses; c++) prob_q[c] <= '0;
        train_q <= (s_axis_tuser == ReqTrain);
        cls_q <= '0;
        idx_q <= '0;
        ep_q  <= '0;
        acc_q <= '0;
      end
      StFwd: begin
        if (rd_en && !last_rd) idx_q <= idx_q + FW'(1);
        if (rvld_q) acc_q <= acc_q + term;
        if (sig_done) begin
          idx_q <= '0;
          acc_q <= '0;
          if (!train_q) prob_q[cls_q] <= sig_y;
          err_q <= $signed({1'b0, tgt_q[cls_q]}) - $signed({1'b0, sig_y});
        end
      end
      StSig: begin
        cls_q <= cls_q + CW'(1);
      end
      StUpd: begin
        if (!re_vld_q) re_q <= $signed({1'b0, rate_c}) * err_q;
        if (rd_en && !last_rd) idx_q <= idx_q + FW'(1);
        if (wr_en && ridx_q == FW'(NumFeatures)) begin
          idx_q <= '0;
          if (cls_q == CW'(NumClasses-1)) begin
            cls_q <= '0;
            ep_q <= ep_q + 14'd1;
          end else cls_q <= cls_q + CW'(1);
        end
      end
      default: ;
    endcase
  end

  // result word
  logic [QW-1:0] risk;
  always_comb begin
    risk = '0;
    for (int c = 1; c < MaxClasses; c++)
      if (prob_q[c] > risk) risk = prob_q[c];
  end
  assign m_axis_tdata = {risk, prob_q[3], prob_q[2], prob_q[1], prob_q[0]};
  assign m_axis_tuser = train_q;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken while result waits");
  a_train_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("train result not zero");
`endif

endmodule

// ===== verif/logistic_classifier_online_train_tb.sv =====
// ----------------------------------------------------------------------------
// logistic_classifier_online_train_tb
// Self-checking bench for the online-trained logistic classifier: drives
// predict and train words under random idling, tracks weights and biases in
// its own fixed-point model and compares every result word field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module logistic_classifier_online_train_tb import lcot_pkg::*; ();

  localparam int NCls = 4;
  localparam int NFeat = 7;

  typedef struct packed {
    logic        was_train;
    logic [15:0] risk;
    logic [15:0] p3;
    logic [15:0] p2;
    logic [15:0] p1;
    logic [15:0] p0;
  } class_result_t;

  // model of weights, biases and settings, with the queue of pending results
  class risk_scoreboard;
    longint wgt[NCls][NFeat];
    longint bia[NCls];
    longint rate;
    longint epochs;
    class_result_t pending[$];
    int errors;
    int n_pred, n_train, n_checked;

    function void init();
      for (int r = 0; r < NCls; r++) begin
        for (int c = 0; c < NFeat; c++) wgt[r][c] = longint'(init_weight(r, c));
        bia[r] = longint'(init_bias(r));
      end
      rate = 655;
      epochs = 1;
      errors = 0;
    endfunction

    function void write_reg(logic idx, logic [16:0] val);
      if (idx == CfgLearnRate) rate = val;
      else epochs = val[13:0];
    endfunction

    function longint fshift(longint v, int s);
      return v >>> s;
    endfunction

    function longint knot(int k);
      return longint'(sig_knot(4'(k)));
    endfunction

    function longint sig_up(longint m);
      longint k, fr;
      k = m >> 16;
      fr = m & 16'hFFFF;
      if (k >= 8) return knot(8);
      return knot(k) + (((knot(k + 1) - knot(k)) * fr) >> 16);
    endfunction

    function longint sigmoid(longint x);
      if (x >= (64'sd8 <<< 16)) return 32768;
      if (x >= 0) return sig_up(x);
      if (-x > (64'sd8 <<< 16)) return 0;
      return 32768 - sig_up(-x);
    endfunction

    function longint class_prob(int r, longint f[NFeat]);
      longint acc;
      acc = bia[r] * 32768;
      for (int c = 0; c < NFeat; c++) acc += wgt[r][c] * f[c];
      return sigmoid(fshift(acc, 15));
    endfunction

    function longint sat24(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
    endfunction

    function longint satq(longint v);
      return v > 32768 ? 32768 : v;
    endfunction

    // note an accepted request word and queue its result
    function void note_request(logic kind, logic [175:0] d);
      longint f[NFeat];
      longint t, err, re, rt, loops, pr, rk;
      class_result_t res;
      for (int c = 0; c < NFeat; c++) f[c] = satq(d[16*c +: 16]);
      res = '0;
      if (kind == ReqTrain) begin
        rt = rate < 7 ? 7 : (rate > 65536 ? 65536 : rate);
        loops = epochs < 1 ? 1 : (epochs > 10000 ? 10000 : epochs);
        for (longint e = 0; e < loops; e++) begin
          for (int r = 0; r < NCls; r++) begin
            t = satq(d[16*(7+r) +: 16]);
            err = t - class_prob(r, f);
            re = rt * err;
            for (int c = 0; c < NFeat; c++)
              wgt[r][c] = sat24(wgt[r][c] + fshift(re * f[c] + (64'sd1 <<< 29), 30));
            bia[r] = sat24(bia[r] + fshift(re + (64'sd1 <<< 16), 17));
          end
        end
        res.was_train = 1'b1;
        n_train++;
      end else begin
        rk = 0;
        for (int r = 0; r < NCls; r++) begin
          pr = class_prob(r, f);
          if (r >= 1 && pr > rk) rk = pr;
          case (r)
            0: res.p0 = pr[15:0];
            1: res.p1 = pr[15:0];
            2: res.p2 = pr[15:0];
            default: res.p3 = pr[15:0];
          endcase
        end
        res.risk = rk[15:0];
        n_pred++;
      end
      pending.insert(pending.size(), res);
    endfunction

    // compare a result word with the oldest expectation
    function void check_result(logic user, logic [79:0] d);
      class_result_t x, a;
      a = {user, d};
      if (pending.size() == 0) begin
        $error("result word with nothing expected: %h", a);
        errors++;
        return;
      end
      x = pending.pop_front();
      n_checked++;
      if (x.was_train !== a.was_train) begin
        $error("was_train expected %0d actual %0d", x.was_train, a.was_train); errors++;
      end
      if (x.p0 !== a.p0) begin
        $error("prob_benign expected %0d actual %0d", x.p0, a.p0); errors++;
      end
      if (x.p1 !== a.p1) begin
        $error("prob_injection expected %0d actual %0d", x.p1, a.p1); errors++;
      end
      if (x.p2 !== a.p2) begin
        $error("prob_exfiltration expected %0d actual %0d", x.p2, a.p2); errors++;
      end
      if (x.p3 !== a.p3) begin
        $error("prob_privilege expected %0d actual %0d", x.p3, a.p3); errors++;
      end
      if (x.risk !== a.risk) begin
        $error("peak_risk expected %0d actual %0d", x.risk, a.risk); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_index_i = 1'b0;
  logic [16:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [175:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic m_axis_tuser;

  risk_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_off = 1'b0;

  logistic_classifier_online_train u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // sample both handshakes at the edge
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) sb.note_request(s_axis_tuser, s_axis_tdata);
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tuser, m_axis_tdata);
  end

  // receiver readiness
  always @(posedge clk_i) begin
    if (hold_off) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic write_cfg(logic idx, logic [16:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    cfg_valid_i <= 1'b0;
  endtask

  // send one request word, with random idle cycles ahead of it
  task automatic send_word(logic kind, logic [175:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // wait until every expected result has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_q();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return 16'd0;
    if (sel == 1) return 16'd32768;
    if (sel == 2) return 16'($urandom);
    return 16'($urandom_range(32768));
  endfunction

  function automatic logic [175:0] rand_word();
    logic [175:0] d;
    for (int i = 0; i < 11; i++) d[16*i +: 16] = rand_q();
    return d;
  endfunction

  function automatic logic [175:0] fill_word(logic [15:0] v);
    logic [175:0] d;
    for (int i = 0; i < 11; i++) d[16*i +: 16] = v;
    return d;
  endfunction

  task automatic random_phase(int n, int s_pct, int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < n; i++)
      send_word(($urandom_range(3) == 0) ? ReqTrain : ReqPredict, rand_word());
    drain();
  endtask

  initial begin
    sb = new();
    sb.init();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: extremes, both kinds, over-range features and targets
    send_word(ReqPredict, fill_word(16'd0));
    send_word(ReqPredict, fill_word(16'd32768));
    send_word(ReqPredict, fill_word(16'hFFFF));
    send_word(ReqPredict, fill_word(16'd16384));
    send_word(ReqTrain, fill_word(16'd32768));
    send_word(ReqPredict, fill_word(16'd32768));
    send_word(ReqTrain, fill_word(16'hFFFF));
    send_word(ReqTrain, fill_word(16'd0));
    send_word(ReqPredict, fill_word(16'd20000));
    drain();
    // rate and epoch extremes, including clamped values
    write_cfg(CfgLearnRate, 17'h1FFFF);
    write_cfg(CfgEpochCount, 17'd0);
    send_word(ReqTrain, fill_word(16'd32768));
    send_word(ReqPredict, fill_word(16'd32768));
    drain();
    write_cfg(CfgLearnRate, 17'd0);
    write_cfg(CfgEpochCount, 17'h3FFF);
    send_word(ReqTrain, rand_word());
    send_word(ReqPredict, rand_word());
    drain();
    write_cfg(CfgLearnRate, 17'd65536);
    write_cfg(CfgEpochCount, 17'd20);
    for (int i = 0; i < 6; i++) send_word(i % 2 ? ReqPredict : ReqTrain, rand_word());
    drain();

    // random phases under different settings
    write_cfg(CfgLearnRate, 17'd655);
    write_cfg(CfgEpochCount, 17'd1);
    random_phase(160, 26, 80);
    write_cfg(CfgLearnRate, 17'd7);
    write_cfg(CfgEpochCount, 17'd3);
    random_phase(160, 80, 26);
    write_cfg(CfgLearnRate, 17'($urandom_range(7, 65536)));
    write_cfg(CfgEpochCount, 17'($urandom_range(1, 5)));
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
      random_phase(180, 0, 0);
    join

    repeat (100) @(posedge clk_i);
    $display("covered %0d predict and %0d train words, %0d results checked",
             sb.n_pred, sb.n_train, sb.n_checked);
    $display("settings swept over rate and epoch extremes with idling on both sides");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // run limit
  initial begin
    #300ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/lcot_pkg.sv
hw/rtl/lcot_sigmoid.sv
hw/rtl/lcot_param_mem.sv
hw/rtl/logistic_classifier_online_train.sv
verif/logistic_classifier_online_train_tb.sv
